>>> rtl/pqft_pkg.sv
// ----------------------------------------------------------------------------
// pqft_pkg
// shared constants, register codes and control types of the facet test
// ----------------------------------------------------------------------------
package pqft_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int TAG_BITS       = 16;
  localparam int CORNER_BITS    = 63;
  localparam int NUM_CORNERS    = 4;
  localparam int CFG_IDX_BITS   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] IDX_CORNER_A = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] IDX_CORNER_B = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] IDX_CORNER_C = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] IDX_CORNER_D = 3'd3;

  // what travels beside the arithmetic
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                inbox;
  } side_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_en_t;

endpackage

>>> rtl/pqft_if.sv
// ----------------------------------------------------------------------------
// pqft interfaces
// point, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pqft_pt_if #(parameter int CB = pqft_pkg::COORD_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [CB-1:0]          point_x;
  logic signed [CB-1:0]          point_y;
  logic signed [CB-1:0]          point_z;
  logic [pqft_pkg::TAG_BITS-1:0] point_tag;

  modport source (output valid, point_x, point_y, point_z, point_tag, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_tag, output ready);
endinterface

interface pqft_res_if;
  logic                          valid;
  logic                          ready;
  logic [pqft_pkg::TAG_BITS-1:0] tag_out;
  logic                          on_facet;

  modport source (output valid, tag_out, on_facet, input ready);
  modport sink   (input valid, tag_out, on_facet, output ready);
endinterface

interface pqft_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pqft_pkg::CFG_IDX_BITS-1:0] index;
  logic [pqft_pkg::CORNER_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/pqft_cfg.sv
// ----------------------------------------------------------------------------
// pqft_cfg
// corner registers, coordinate unpacking and bounding box
// ----------------------------------------------------------------------------
module pqft_cfg #(
  parameter int CB = pqft_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pqft_cfg_if.sink             cfg,
  output logic signed [CB-1:0] corner [4][3],
  output logic signed [CB-1:0] box_lo [3],
  output logic signed [CB-1:0] box_hi [3]
);
  import pqft_pkg::*;

  // fields past the register read as zero
  localparam int PADW = (3 * CB > CORNER_BITS) ? 3 * CB : CORNER_BITS;

  logic [CORNER_BITS-1:0] corner_r [NUM_CORNERS];
  logic [PADW-1:0]        pad [NUM_CORNERS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CORNERS; k++) corner_r[k] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        IDX_CORNER_A: corner_r[0] <= cfg.data;
        IDX_CORNER_B: corner_r[1] <= cfg.data;
        IDX_CORNER_C: corner_r[2] <= cfg.data;
        IDX_CORNER_D: corner_r[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      pad[k] = PADW'(corner_r[k]);
      for (int i = 0; i < 3; i++) corner[k][i] = $signed(pad[k][i*CB +: CB]);
    end
  end

  // two-level min/max per axis, straight from the corner registers so a
  // point right after a corner write already sees the new box
  always_comb begin
    logic signed [CB-1:0] lo01, lo23, hi01, hi23;
    for (int i = 0; i < 3; i++) begin
      lo01 = (corner[1][i] < corner[0][i]) ? corner[1][i] : corner[0][i];
      lo23 = (corner[3][i] < corner[2][i]) ? corner[3][i] : corner[2][i];
      hi01 = (corner[1][i] > corner[0][i]) ? corner[1][i] : corner[0][i];
      hi23 = (corner[3][i] > corner[2][i]) ? corner[3][i] : corner[2][i];
      box_lo[i] = (lo23 < lo01) ? lo23 : lo01;
      box_hi[i] = (hi23 > hi01) ? hi23 : hi01;
    end
  end

endmodule

>>> rtl/pqft_front.sv
// ----------------------------------------------------------------------------
// pqft_front
// stage 1: bounding box test and corner-minus-point vectors
// ----------------------------------------------------------------------------
module pqft_front #(
  parameter int CB = pqft_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [CB-1:0]          px,
  input  logic signed [CB-1:0]          py,
  input  logic signed [CB-1:0]          pz,
  input  logic [pqft_pkg::TAG_BITS-1:0] tag,
  input  logic signed [CB-1:0]          corner [4][3],
  input  logic signed [CB-1:0]          box_lo [3],
  input  logic signed [CB-1:0]          box_hi [3],
  output logic signed [CB:0]            d      [4][3],
  output pqft_pkg::side_t               side
);
  import pqft_pkg::*;

  logic signed [CB-1:0] p [3];
  logic signed [CB:0]   d_nxt [4][3];
  logic signed [CB:0]   d_r   [4][3];
  side_t                side_nxt;
  side_t                side_r;

  assign p[0] = px;
  assign p[1] = py;
  assign p[2] = pz;

  always_comb begin
    side_nxt.tag   = tag;
    side_nxt.inbox = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (p[i] < box_lo[i] || p[i] > box_hi[i]) side_nxt.inbox = 1'b0;
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) d_nxt[k][i] = (CB+1)'(corner[k][i]) - (CB+1)'(p[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= side_nxt;
    end
  end

  assign d    = d_r;
  assign side = side_r;

endmodule

>>> rtl/pqft_cross.sv
// ----------------------------------------------------------------------------
// pqft_cross
// stages 2 and 3: the four consecutive cross products
// ----------------------------------------------------------------------------
module pqft_cross #(
  parameter int CB = pqft_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en2,
  input  logic                    en3,
  input  logic signed [CB:0]      d [4][3],
  input  pqft_pkg::side_t         side_in,
  output logic signed [2*CB+2:0]  x [4][3],
  output pqft_pkg::side_t         side_out
);
  import pqft_pkg::*;

  localparam int PW = 2 * CB + 2;
  localparam int XW = 2 * CB + 3;

  logic signed [PW-1:0] prod_nxt [4][3][2];
  logic signed [PW-1:0] prod_r   [4][3][2];
  logic signed [XW-1:0] x_nxt    [4][3];
  logic signed [XW-1:0] x_r      [4][3];
  side_t                side2_r;
  side_t                side3_r;

  // cross k is d[k+1] x d[k], wrapping at the last corner
  for (genvar k = 0; k < 4; k++) begin : g_cross
    for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int UK = (k + 1) % 4;
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      assign prod_nxt[k][i][0] = PW'(d[UK][I1]) * PW'(d[k][I2]);
      assign prod_nxt[k][i][1] = PW'(d[UK][I2]) * PW'(d[k][I1]);
      assign x_nxt[k][i]       = XW'(prod_r[k][i][0]) - XW'(prod_r[k][i][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      prod_r  <= prod_nxt;
      side2_r <= side_in;
    end
    if (en3) begin
      x_r     <= x_nxt;
      side3_r <= side2_r;
    end
  end

  assign x        = x_r;
  assign side_out = side3_r;

endmodule

>>> rtl/pqft_dot.sv
// ----------------------------------------------------------------------------
// pqft_dot
// stages 4 to 6: split dot products of adjacent crosses and sign decision
// ----------------------------------------------------------------------------
module pqft_dot #(
  parameter int CB = pqft_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en4,
  input  logic                          en5,
  input  logic                          en6,
  input  logic signed [2*CB+2:0]        x [4][3],
  input  pqft_pkg::side_t               side_in,
  output logic [pqft_pkg::TAG_BITS-1:0] tag_out,
  output logic                          on_facet
);
  import pqft_pkg::*;

  localparam int XW = 2 * CB + 3;
  localparam int K  = (XW + 1) / 2;   // low half, unsigned
  localparam int HW = XW - K;         // high half, signed
  localparam int FW = 2 * XW;
  localparam int SW = FW + 2;

  logic signed [2*HW-1:0] hh_nxt [4][3];
  logic signed [XW:0]     hl_nxt [4][3];
  logic signed [XW:0]     lh_nxt [4][3];
  logic [2*K-1:0]         ll_nxt [4][3];
  logic signed [2*HW-1:0] hh_r   [4][3];
  logic signed [XW:0]     hl_r   [4][3];
  logic signed [XW:0]     lh_r   [4][3];
  logic [2*K-1:0]         ll_r   [4][3];
  logic signed [FW-1:0]   term_nxt [4][3];
  logic signed [FW-1:0]   term_r   [4][3];
  logic [3:0]             neg;
  side_t                  side4_r;
  side_t                  side5_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic                   on_r;

  // dot j pairs crosses (0,1) (1,2) (2,3) and (0,3)
  for (genvar j = 0; j < 4; j++) begin : g_dot
    localparam int LA = (j == 3) ? 0 : j;
    localparam int LB = (j == 3) ? 3 : j + 1;
    for (genvar i = 0; i < 3; i++) begin : g_term
      logic signed [HW-1:0] ah, bh;
      logic [K-1:0]         al, bl;
      assign ah = $signed(x[LA][i][XW-1:K]);
      assign bh = $signed(x[LB][i][XW-1:K]);
      assign al = x[LA][i][K-1:0];
      assign bl = x[LB][i][K-1:0];
      assign hh_nxt[j][i] = (2*HW)'(ah) * (2*HW)'(bh);
      assign hl_nxt[j][i] = (XW+1)'(ah) * (XW+1)'($signed({1'b0, bl}));
      assign lh_nxt[j][i] = (XW+1)'(bh) * (XW+1)'($signed({1'b0, al}));
      assign ll_nxt[j][i] = (2*K)'(al) * (2*K)'(bl);
      assign term_nxt[j][i] = (FW'(hh_r[j][i]) << (2 * K))
                            + ((FW'(hl_r[j][i]) + FW'(lh_r[j][i])) << K)
                            + FW'($signed({1'b0, ll_r[j][i]}));
    end
  end

  always_comb begin
    logic signed [SW-1:0] sum;
    for (int j = 0; j < 4; j++) begin
      sum    = SW'(term_r[j][0]) + SW'(term_r[j][1]) + SW'(term_r[j][2]);
      neg[j] = sum[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      hh_r    <= hh_nxt;
      hl_r    <= hl_nxt;
      lh_r    <= lh_nxt;
      ll_r    <= ll_nxt;
      side4_r <= side_in;
    end
    if (en5) begin
      term_r  <= term_nxt;
      side5_r <= side4_r;
    end
    if (en6) begin
      tag_r <= side5_r.tag;
      on_r  <= side5_r.inbox & ~(|neg);
    end
  end

  assign tag_out  = tag_r;
  assign on_facet = on_r;

endmodule

>>> rtl/point_in_quad_facet_test.sv
// ----------------------------------------------------------------------------
// point_in_quad_facet_test
// Tests streamed 3D points against one quadrilateral facet.
//
// cfg_ch writes the four packed corners (index 0..3 = corner a..d, other
// indexes are dropped); it is always ready. It must be written only while no
// point is in flight; the block itself does not enforce this. Reset clears
// all corners to zero, a degenerate facet that holds only the origin.
// in_ch takes one point word per cycle while in_ch.ready is high
// (coordinates plus a tag); out_ch returns one word per point with the tag
// and the on_facet flag, in order. out_ch.valid comes from the last of six
// registered stages: one stage for the box test and difference vectors,
// two for the cross products, three for the dot products, which are split
// into half-width partial products and summed before the sign is taken.
// Throughput is one point per cycle while out_ch does not stall.
// When out_ch stalls, each stage holds its word and bubbles behind it fill
// up; in_ch.ready drops only once all six stages are full, and nothing is
// lost or repeated.
// ----------------------------------------------------------------------------
module point_in_quad_facet_test #(
  parameter int COORD_BITS = pqft_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pqft_cfg_if.sink    cfg_ch,
  pqft_pt_if.sink     in_ch,
  pqft_res_if.source  out_ch
);
  import pqft_pkg::*;

  localparam int NSTG = 6;

  logic signed [COORD_BITS-1:0]   corner [4][3];
  logic signed [COORD_BITS-1:0]   box_lo [3];
  logic signed [COORD_BITS-1:0]   box_hi [3];
  logic signed [COORD_BITS:0]     d      [4][3];
  logic signed [2*COORD_BITS+2:0] x      [4][3];
  side_t                          side1;
  side_t                          side3;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] src;
  pipe_en_t        en;

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign src   = {v_r[NSTG-2:0], in_ch.valid};
  assign v_nxt = (rdy & src) | (~rdy & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];
  assign en.s5 = rdy[4];
  assign en.s6 = rdy[5];

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = v_r[NSTG-1];

  pqft_cfg #(.CB(COORD_BITS)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .corner (corner),
    .box_lo (box_lo),
    .box_hi (box_hi)
  );

  pqft_front #(.CB(COORD_BITS)) u_front (
    .clk    (clk),
    .en     (en.s1),
    .px     (in_ch.point_x),
    .py     (in_ch.point_y),
    .pz     (in_ch.point_z),
    .tag    (in_ch.point_tag),
    .corner (corner),
    .box_lo (box_lo),
    .box_hi (box_hi),
    .d      (d),
    .side   (side1)
  );

  pqft_cross #(.CB(COORD_BITS)) u_cross (
    .clk      (clk),
    .en2      (en.s2),
    .en3      (en.s3),
    .d        (d),
    .side_in  (side1),
    .x        (x),
    .side_out (side3)
  );

  pqft_dot #(.CB(COORD_BITS)) u_dot (
    .clk      (clk),
    .en4      (en.s4),
    .en5      (en.s5),
    .en6      (en.s6),
    .x        (x),
    .side_in  (side3),
    .tag_out  (out_ch.tag_out),
    .on_facet (out_ch.on_facet)
  );

  // a full stage that cannot move keeps its word
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(v_r & ~rdy) & ~v_r) == '0))
    else $error("stalled stage lost its word");

  // input backpressure only when the whole pipe is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled with a free stage");

  // words in flight change only by accepted input words and taken output words
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v_r) == $past($countones(v_r))
                + $past(32'(in_ch.valid && in_ch.ready))
                - $past(32'(out_ch.valid && out_ch.ready))))
    else $error("pipeline occupancy mismatch");

endmodule
